/* rtl/dma_block_copy_controller_core_macros.svh */
// Assertion macros shared by the DMA block copy controller RTL.
`ifndef DMA_BLOCK_COPY_CONTROLLER_CORE_MACROS_SVH
`define DMA_BLOCK_COPY_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define DBCC_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define DBCC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/dbcc_pkg.sv */
// Types and constants of the DMA block copy controller.
package dbcc_pkg;

	localparam int ADDR_W       = 16;
	localparam int DATA_W       = 16;
	localparam int DIR_W        = 2;
	localparam int CFG_IDX_W    = 2;
	localparam int WORD_BITS_DEF = 16;

	// register indexes on the configuration channel
	localparam logic [CFG_IDX_W-1:0] REG_SOURCE_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DEST_BASE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_WORD_COUNT  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION   = 2'd3;

	// input item modes
	localparam logic MODE_START = 1'b0;
	localparam logic MODE_DATA  = 1'b1;

	// bus targets
	localparam logic TGT_MEM = 1'b0;
	localparam logic TGT_ACC = 1'b1;

	// status codes
	localparam logic [1:0] STAT_NONE    = 2'd0;
	localparam logic [1:0] STAT_MEM2ACC = 2'd1;
	localparam logic [1:0] STAT_ACC2MEM = 2'd2;

	typedef enum logic [1:0] {
		KIND_READ  = 2'd0,
		KIND_WRITE = 2'd1,
		KIND_DONE  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [ADDR_W-1:0] source_base;
		logic [ADDR_W-1:0] dest_base;
		logic [ADDR_W-1:0] word_count;
		logic [DIR_W-1:0]  direction_bits;
	} cfg_t;

	typedef struct packed {
		kind_t             kind;
		logic              target;
		logic [ADDR_W-1:0] address;
		logic [DATA_W-1:0] write_data;
		logic [1:0]        status;
		logic              last_of_run;
	} res_t;

	// handshake between the step engine and the result buffer
	typedef struct packed {
		logic       load;
		logic [1:0] count;
	} load_t;

endpackage

/* rtl/dbcc_ifs.sv */
// Channel interfaces: input items, result items, configuration writes.
interface dbcc_item_if;
	logic                        valid;
	logic                        ready;
	logic                        mode;
	logic [dbcc_pkg::DATA_W-1:0] read_data;
	modport source (output valid, mode, read_data, input ready);
	modport sink (input valid, mode, read_data, output ready);
endinterface

interface dbcc_result_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  kind;
	logic                        target;
	logic [dbcc_pkg::ADDR_W-1:0] address;
	logic [dbcc_pkg::DATA_W-1:0] write_data;
	logic [1:0]                  status;
	logic                        last_of_run;
	modport source (output valid, kind, target, address, write_data, status, last_of_run,
		input ready);
	modport sink (input valid, kind, target, address, write_data, status, last_of_run,
		output ready);
endinterface

interface dbcc_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [dbcc_pkg::CFG_IDX_W-1:0] index;
	logic [dbcc_pkg::ADDR_W-1:0]    data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* rtl/dbcc_cfg_regs.sv */
// Configuration register file written over the config channel.
module dbcc_cfg_regs (
	input  logic               clk,
	input  logic               arst_n,
	dbcc_cfg_if.sink           cfg,
	output dbcc_pkg::cfg_t     regs
);

	dbcc_pkg::cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dbcc_pkg::REG_SOURCE_BASE: regs_q.source_base <= cfg.data;
				dbcc_pkg::REG_DEST_BASE:   regs_q.dest_base   <= cfg.data;
				dbcc_pkg::REG_WORD_COUNT:  regs_q.word_count  <= cfg.data;
				dbcc_pkg::REG_DIRECTION:
					regs_q.direction_bits <= cfg.data[dbcc_pkg::DIR_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* rtl/dbcc_engine.sv */
// Input register and transfer sequencing: turns one item into up to two results.
`include "dma_block_copy_controller_core_macros.svh"
module dbcc_engine #(
	parameter int WORD_BITS = dbcc_pkg::WORD_BITS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	dbcc_item_if.sink        item,
	input  dbcc_pkg::cfg_t   regs,
	input  logic             load_ok,
	output dbcc_pkg::load_t  ld,
	output dbcc_pkg::res_t   res0,
	output dbcc_pkg::res_t   res1
);

	localparam int DATA_BITS = (WORD_BITS < dbcc_pkg::DATA_W) ? WORD_BITS : dbcc_pkg::DATA_W;
	localparam int DW = dbcc_pkg::DATA_W;
	localparam int AW = dbcc_pkg::ADDR_W;

	logic                 valid_s1;
	logic                 mode_s1;
	logic [DATA_BITS-1:0] data_s1;

	logic          busy_q;
	logic [AW-1:0] word_index_q;
	logic [1:0]    status_q;

	logic          go;
	logic          rd_tgt;
	logic [1:0]    st;
	logic [AW-1:0] nidx;
	logic          finish;
	logic [1:0]    n;

	assign go         = valid_s1 && load_ok;
	assign item.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item.ready) begin
			valid_s1 <= item.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item.ready && item.valid) begin
			mode_s1 <= item.mode;
			data_s1 <= item.read_data[DATA_BITS-1:0];
		end
	end

	assign rd_tgt = regs.direction_bits[0] ? dbcc_pkg::TGT_MEM : dbcc_pkg::TGT_ACC;
	assign st     = regs.direction_bits[1] ? dbcc_pkg::STAT_ACC2MEM : dbcc_pkg::STAT_MEM2ACC;
	assign nidx   = word_index_q + AW'(1);
	// wrap to zero also ends the run
	assign finish = (nidx == '0) || (nidx >= regs.word_count);

	always_comb begin
		n    = 2'd0;
		res0 = '0;
		res1 = '0;
		if (mode_s1 == dbcc_pkg::MODE_START) begin
			if (!busy_q) begin
				n = 2'd1;
				res0.last_of_run = 1'b1;
				if (regs.word_count == '0 || regs.direction_bits == '0) begin
					res0.kind   = dbcc_pkg::KIND_DONE;
					res0.status = st;
				end else begin
					res0.kind    = dbcc_pkg::KIND_READ;
					res0.target  = rd_tgt;
					res0.address = regs.source_base;
				end
			end
		end else if (busy_q) begin
			n = 2'd2;
			res0.kind       = dbcc_pkg::KIND_WRITE;
			res0.target     = !rd_tgt;
			res0.address    = regs.dest_base + word_index_q;
			res0.write_data = DW'(data_s1);
			res1.last_of_run = 1'b1;
			if (finish) begin
				res1.kind   = dbcc_pkg::KIND_DONE;
				res1.status = status_q;
			end else begin
				res1.kind    = dbcc_pkg::KIND_READ;
				res1.target  = rd_tgt;
				res1.address = regs.source_base + nidx;
			end
		end
	end

	assign ld.load  = go;
	assign ld.count = n;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			word_index_q <= '0;
			status_q     <= dbcc_pkg::STAT_NONE;
		end else if (go) begin
			if (mode_s1 == dbcc_pkg::MODE_START) begin
				if (!busy_q && regs.word_count != '0 && regs.direction_bits != '0) begin
					busy_q       <= 1'b1;
					word_index_q <= '0;
					status_q     <= st;
				end
			end else if (busy_q) begin
				if (finish) begin
					busy_q       <= 1'b0;
					word_index_q <= '0;
				end else begin
					word_index_q <= nidx;
				end
			end
		end
	end

	`DBCC_ASSERT_NOW(a_idle_index_zero, !busy_q, word_index_q == '0, "index nonzero while idle")
	`DBCC_ASSERT_NEXT(a_finish_goes_idle, go && mode_s1 && busy_q && finish, !busy_q, "run did not end")
	`DBCC_ASSERT_NOW(a_last_marks_end, go && n != 2'd0, (n == 2'd1 && res0.last_of_run) || (n == 2'd2 && res1.last_of_run && !res0.last_of_run), "bad last_of_run")

endmodule

/* rtl/dbcc_out_buf.sv */
// Two-slot result buffer that drains one beat per cycle onto the result channel while it is ready.
`include "dma_block_copy_controller_core_macros.svh"
module dbcc_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  dbcc_pkg::load_t  ld,
	input  dbcc_pkg::res_t   res0,
	input  dbcc_pkg::res_t   res1,
	output logic             load_ok,
	dbcc_result_if.source    result
);

	dbcc_pkg::res_t slot0_q;
	dbcc_pkg::res_t slot1_q;
	dbcc_pkg::res_t head;
	logic [1:0]     cnt_q;
	logic           head_q;
	logic           fire;

	assign fire    = result.valid && result.ready;
	// take a new group once the buffer is empty or its final beat leaves now
	assign load_ok = (cnt_q == 2'd0) || (cnt_q == 2'd1 && fire);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 2'd0;
			head_q <= 1'b0;
		end else if (ld.load && ld.count != 2'd0) begin
			cnt_q  <= ld.count;
			head_q <= 1'b0;
		end else if (fire) begin
			cnt_q  <= cnt_q - 2'd1;
			head_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld.load && ld.count != 2'd0) begin
			slot0_q <= res0;
			slot1_q <= res1;
		end
	end

	assign head               = head_q ? slot1_q : slot0_q;
	assign result.valid       = cnt_q != 2'd0;
	assign result.kind        = head.kind;
	assign result.target      = head.target;
	assign result.address     = head.address;
	assign result.write_data  = head.write_data;
	assign result.status      = head.status;
	assign result.last_of_run = head.last_of_run;

	`DBCC_ASSERT_NOW(a_cnt_range, 1'b1, cnt_q != 2'd3, "buffer count out of range")
	`DBCC_ASSERT_NOW(a_head_second, result.valid && head_q, cnt_q == 2'd1, "second slot with beats behind it")
	`DBCC_ASSERT_NEXT(a_pair_drains, fire && cnt_q == 2'd2, result.valid && head_q, "second beat lost")

endmodule

/* rtl/dma_block_copy_controller_core.sv */
// Top level of the single-channel DMA block copy controller.
// An accepted item is registered in the input stage; its results are loaded into
// the two-slot result buffer once that buffer can take them. A start item yields
// one beat; a start can be taken every cycle while the result channel is ready. In
// a run a data item yields a write beat, then a read or done beat; the next item
// waits until that pair drains. Configuration is always ready and must be written
// only while no transfer beats are in flight.
module dma_block_copy_controller_core #(
	parameter int WORD_BITS = dbcc_pkg::WORD_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	dbcc_item_if.sink     item,
	dbcc_result_if.source result,
	dbcc_cfg_if.sink      cfg
);

	dbcc_pkg::cfg_t  regs;
	dbcc_pkg::load_t ld;
	dbcc_pkg::res_t  res0;
	dbcc_pkg::res_t  res1;
	logic            load_ok;

	dbcc_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	dbcc_engine #(
		.WORD_BITS (WORD_BITS)
	) u_engine (
		.clk     (clk),
		.arst_n  (arst_n),
		.item    (item),
		.regs    (regs),
		.load_ok (load_ok),
		.ld      (ld),
		.res0    (res0),
		.res1    (res1)
	);

	dbcc_out_buf u_out (
		.clk     (clk),
		.arst_n  (arst_n),
		.ld      (ld),
		.res0    (res0),
		.res1    (res1),
		.load_ok (load_ok),
		.result  (result)
	);

endmodule
